// ===== rtl/tkh_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Top-k heap selector package
// Shared constants, entry type, codes and the ranking key function.
// ----------------------------------------------------------------------------
package tkh_pkg;

    localparam int MAX_ENTRIES = 64;
    localparam int ENTITY_BITS = 16;
    localparam int SCORE_BITS  = 32;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int FILL_W      = $clog2(MAX_ENTRIES + 1);
    localparam int CHILD_W     = IDX_W + 2;
    localparam int KEY_W       = SCORE_BITS + 1;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_FLUSH  = 1'b1;

    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_ENTRY  = 2'd1;
    localparam logic [1:0] KIND_EMPTY  = 2'd2;

    typedef struct packed {
        logic [ENTITY_BITS-1:0] entity;
        logic [SCORE_BITS-1:0]  score;
        logic                   owned;
    } tkh_entry_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_UP_RD,
        ST_UP_CMP,
        ST_ROOT_RD,
        ST_ROOT_CMP,
        ST_DN_RD,
        ST_DN_CMP,
        ST_FL_SCAN,
        ST_FL_EMIT,
        ST_RESULT
    } tkh_state_t;

    function automatic logic [KEY_W-1:0] rank_key(tkh_entry_t e);
        return {~e.owned, e.score};
    endfunction

endpackage

// ===== rtl/tkh_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Top-k heap selector channels
// Candidate, result and capacity channels with valid/ready transfer.
// ----------------------------------------------------------------------------
interface tkh_req_if;
    import tkh_pkg::*;
    logic                   valid;
    logic                   ready;
    logic                   cmd;
    logic [ENTITY_BITS-1:0] entity_id;
    logic                   owned_flag;
    logic [SCORE_BITS-1:0]  distance_score;

    modport source (output valid, cmd, entity_id, owned_flag, distance_score, input ready);
    modport sink   (input valid, cmd, entity_id, owned_flag, distance_score, output ready);
endinterface

interface tkh_rsp_if;
    import tkh_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [1:0]             result_kind;
    logic                   accepted;
    logic                   evicted;
    logic [ENTITY_BITS-1:0] out_entity;
    logic [SCORE_BITS-1:0]  out_score;
    logic                   out_owned;
    logic [FILL_W-1:0]      fill_count;
    logic                   last;

    modport source (output valid, result_kind, accepted, evicted, out_entity, out_score,
                    out_owned, fill_count, last, input ready);
    modport sink   (input valid, result_kind, accepted, evicted, out_entity, out_score,
                    out_owned, fill_count, last, output ready);
endinterface

interface tkh_cfg_if;
    import tkh_pkg::*;
    logic              valid;
    logic              ready;
    logic [FILL_W-1:0] capacity;

    modport source (output valid, capacity, input ready);
    modport sink   (input valid, capacity, output ready);
endinterface

// ===== rtl/tkh_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module tkh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/bounded_top_k_heap_selector_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded top-k heap selector
// Max-heap of kept entries in two mirrored RAMs; root is the worst entry.
// ----------------------------------------------------------------------------
// Insert while not full: placed at the end, then sifts up through ST_UP_RD and ST_UP_CMP.
// Insert while full: root read and compared; rejected unless it ranks below the root, else sifts down.
// Flush of n entries: n results, one per scan of the kept entries.
// One item in flight; the result register takes the next result when free.
// Reset clears fill count, sets capacity to 64; RAM contents are not cleared.
// ----------------------------------------------------------------------------
module bounded_top_k_heap_selector_top (
    input  logic       clk,
    input  logic       rst_n,
    tkh_req_if.sink    req,
    tkh_rsp_if.source  rsp,
    tkh_cfg_if.sink    cfg
);
    import tkh_pkg::*;

    tkh_state_t state_reg, state_next;
    logic [FILL_W-1:0] cap_reg;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [IDX_W-1:0]  pos_reg, pos_next;
    tkh_entry_t        cand_reg, cand_next;
    tkh_entry_t        gone_reg, gone_next;
    logic              acc_reg, acc_next;
    logic              ev_reg, ev_next;
    logic [1:0]        kind_reg, kind_next;

    logic [FILL_W-1:0] scan_reg, scan_next;
    logic              cmp_valid_reg, cmp_valid_next;
    logic [IDX_W-1:0]  cmp_idx_reg, cmp_idx_next;
    tkh_entry_t        best_reg, best_next;
    logic [IDX_W-1:0]  best_idx_reg, best_idx_next;
    logic              best_found_reg, best_found_next;
    logic [ENTITY_BITS-1:0] low_ent_reg, low_ent_next;
    logic [IDX_W-1:0]  low_idx_reg, low_idx_next;
    logic              low_valid_reg, low_valid_next;
    logic [FILL_W-1:0] emit_cnt_reg, emit_cnt_next;

    logic              out_valid_reg;
    logic [1:0]        out_kind_reg;
    logic              out_acc_reg;
    logic              out_ev_reg;
    tkh_entry_t        out_ent_reg;
    logic [FILL_W-1:0] out_fill_reg;
    logic              out_last_reg;

    logic              out_load;
    logic [1:0]        ld_kind;
    logic              ld_acc;
    logic              ld_ev;
    tkh_entry_t        ld_ent;
    logic [FILL_W-1:0] ld_fill;
    logic              ld_last;
    logic              out_free;

    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    tkh_entry_t        mem_wdata;
    logic [IDX_W-1:0]  raddr_a;
    logic [IDX_W-1:0]  raddr_b;
    tkh_entry_t        rdata_a;
    tkh_entry_t        rdata_b;

    logic [FILL_W-1:0] cap_live;
    logic [IDX_W-1:0]  parent_idx;
    logic [CHILD_W-1:0] l_idx;
    logic [CHILD_W-1:0] r_idx;
    logic              l_ok;
    logic              r_ok;
    logic              req_xfer;
    tkh_entry_t        req_ent;
    logic              eligible;
    logic              better;
    logic              scan_done;
    logic              emit_last;
    logic [KEY_W-1:0]  win_key;
    logic [IDX_W-1:0]  win_idx;
    tkh_entry_t        win_ent;

    tkh_ram #(.WIDTH($bits(tkh_entry_t)), .DEPTH(MAX_ENTRIES)) u_ram_a (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (raddr_a),
        .rdata (rdata_a)
    );

    tkh_ram #(.WIDTH($bits(tkh_entry_t)), .DEPTH(MAX_ENTRIES)) u_ram_b (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (raddr_b),
        .rdata (rdata_b)
    );

    assign cfg.ready = 1'b1;
    assign req.ready = (state_reg == ST_IDLE);
    assign req_xfer  = req.valid && req.ready;
    assign out_free  = !out_valid_reg || rsp.ready;

    assign req_ent.entity = req.entity_id;
    assign req_ent.score  = req.distance_score;
    assign req_ent.owned  = req.owned_flag;

    assign cap_live = (cap_reg == '0) ? FILL_W'(1) :
                      (cap_reg > FILL_W'(MAX_ENTRIES)) ? FILL_W'(MAX_ENTRIES) : cap_reg;

    assign parent_idx = (pos_reg - IDX_W'(1)) >> 1;
    assign l_idx      = CHILD_W'({pos_reg, 1'b1});
    assign r_idx      = l_idx + CHILD_W'(1);
    assign l_ok       = l_idx < CHILD_W'(fill_reg);
    assign r_ok       = r_idx < CHILD_W'(fill_reg);

    assign eligible  = !low_valid_reg || (rdata_a.entity > low_ent_reg) ||
                       ((rdata_a.entity == low_ent_reg) && (cmp_idx_reg > low_idx_reg));
    assign better    = !best_found_reg || (rdata_a.entity < best_reg.entity);
    assign scan_done = cmp_valid_reg && (({1'b0, cmp_idx_reg} + FILL_W'(1)) == fill_reg);
    assign emit_last = (emit_cnt_reg + FILL_W'(1)) == fill_reg;

    always_comb
    begin
        win_key = rank_key(cand_reg);
        win_idx = pos_reg;
        win_ent = cand_reg;
        if (rank_key(rdata_a) > win_key)
        begin
            win_key = rank_key(rdata_a);
            win_idx = l_idx[IDX_W-1:0];
            win_ent = rdata_a;
        end
        if (r_ok && (rank_key(rdata_b) > win_key))
        begin
            win_idx = r_idx[IDX_W-1:0];
            win_ent = rdata_b;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        fill_next       = fill_reg;
        pos_next        = pos_reg;
        cand_next       = cand_reg;
        gone_next       = gone_reg;
        acc_next        = acc_reg;
        ev_next         = ev_reg;
        kind_next       = kind_reg;
        scan_next       = scan_reg;
        cmp_valid_next  = 1'b0;
        cmp_idx_next    = scan_reg[IDX_W-1:0];
        best_next       = best_reg;
        best_idx_next   = best_idx_reg;
        best_found_next = best_found_reg;
        low_ent_next    = low_ent_reg;
        low_idx_next    = low_idx_reg;
        low_valid_next  = low_valid_reg;
        emit_cnt_next   = emit_cnt_reg;

        mem_we    = 1'b0;
        mem_waddr = pos_reg;
        mem_wdata = cand_reg;
        raddr_a   = parent_idx;
        raddr_b   = r_idx[IDX_W-1:0];

        out_load = 1'b0;
        ld_kind  = kind_reg;
        ld_acc   = acc_reg;
        ld_ev    = ev_reg;
        ld_ent   = ev_reg ? gone_reg : '0;
        ld_fill  = fill_reg;
        ld_last  = 1'b1;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_xfer)
                begin
                    cand_next = req_ent;
                    kind_next = KIND_INSERT;
                    acc_next  = 1'b0;
                    ev_next   = 1'b0;
                    if (req.cmd == CMD_FLUSH)
                    begin
                        if (fill_reg == '0)
                        begin
                            kind_next  = KIND_EMPTY;
                            state_next = ST_RESULT;
                        end
                        else
                        begin
                            scan_next       = '0;
                            low_valid_next  = 1'b0;
                            best_found_next = 1'b0;
                            emit_cnt_next   = '0;
                            state_next      = ST_FL_SCAN;
                        end
                    end
                    else if (fill_reg < cap_live)
                    begin
                        pos_next   = fill_reg[IDX_W-1:0];
                        fill_next  = fill_reg + FILL_W'(1);
                        acc_next   = 1'b1;
                        state_next = ST_UP_RD;
                    end
                    else
                    begin
                        state_next = ST_ROOT_RD;
                    end
                end
            end

            ST_UP_RD:
            begin
                if (pos_reg == '0)
                begin
                    mem_we     = 1'b1;
                    state_next = ST_RESULT;
                end
                else
                begin
                    state_next = ST_UP_CMP;
                end
            end

            ST_UP_CMP:
            begin
                mem_we = 1'b1;
                if (rank_key(rdata_a) < rank_key(cand_reg))
                begin
                    mem_wdata  = rdata_a;
                    pos_next   = parent_idx;
                    state_next = ST_UP_RD;
                end
                else
                begin
                    state_next = ST_RESULT;
                end
            end

            ST_ROOT_RD:
            begin
                raddr_a    = '0;
                state_next = ST_ROOT_CMP;
            end

            ST_ROOT_CMP:
            begin
                if (rank_key(cand_reg) >= rank_key(rdata_a))
                begin
                    state_next = ST_RESULT;
                end
                else
                begin
                    gone_next  = rdata_a;
                    acc_next   = 1'b1;
                    ev_next    = 1'b1;
                    pos_next   = '0;
                    state_next = ST_DN_RD;
                end
            end

            ST_DN_RD:
            begin
                raddr_a = l_idx[IDX_W-1:0];
                if (!l_ok)
                begin
                    mem_we     = 1'b1;
                    state_next = ST_RESULT;
                end
                else
                begin
                    state_next = ST_DN_CMP;
                end
            end

            ST_DN_CMP:
            begin
                mem_we = 1'b1;
                if (win_idx == pos_reg)
                begin
                    state_next = ST_RESULT;
                end
                else
                begin
                    mem_wdata  = win_ent;
                    pos_next   = win_idx;
                    state_next = ST_DN_RD;
                end
            end

            ST_FL_SCAN:
            begin
                raddr_a = scan_reg[IDX_W-1:0];
                if (scan_reg < fill_reg)
                begin
                    cmp_valid_next = 1'b1;
                    scan_next      = scan_reg + FILL_W'(1);
                end
                if (cmp_valid_reg && eligible && better)
                begin
                    best_next       = rdata_a;
                    best_idx_next   = cmp_idx_reg;
                    best_found_next = 1'b1;
                end
                if (scan_done)
                begin
                    state_next = ST_FL_EMIT;
                end
            end

            ST_FL_EMIT:
            begin
                if (out_free)
                begin
                    out_load        = 1'b1;
                    ld_kind         = KIND_ENTRY;
                    ld_acc          = 1'b0;
                    ld_ev           = 1'b0;
                    ld_ent          = best_reg;
                    ld_fill         = '0;
                    ld_last         = emit_last;
                    emit_cnt_next   = emit_cnt_reg + FILL_W'(1);
                    low_ent_next    = best_reg.entity;
                    low_idx_next    = best_idx_reg;
                    low_valid_next  = 1'b1;
                    best_found_next = 1'b0;
                    scan_next       = '0;
                    if (emit_last)
                    begin
                        fill_next  = '0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_FL_SCAN;
                    end
                end
            end

            ST_RESULT:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cap_reg        <= FILL_W'(MAX_ENTRIES);
            fill_reg       <= '0;
            scan_reg       <= '0;
            cmp_valid_reg  <= 1'b0;
            best_found_reg <= 1'b0;
            low_valid_reg  <= 1'b0;
            emit_cnt_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            fill_reg       <= fill_next;
            scan_reg       <= scan_next;
            cmp_valid_reg  <= cmp_valid_next;
            best_found_reg <= best_found_next;
            low_valid_reg  <= low_valid_next;
            emit_cnt_reg   <= emit_cnt_next;
            out_valid_reg  <= out_load || (out_valid_reg && !rsp.ready);
            if (cfg.valid && cfg.ready)
            begin
                cap_reg <= cfg.capacity;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg      <= pos_next;
        cand_reg     <= cand_next;
        gone_reg     <= gone_next;
        acc_reg      <= acc_next;
        ev_reg       <= ev_next;
        kind_reg     <= kind_next;
        cmp_idx_reg  <= cmp_idx_next;
        best_reg     <= best_next;
        best_idx_reg <= best_idx_next;
        low_ent_reg  <= low_ent_next;
        low_idx_reg  <= low_idx_next;
        if (out_load)
        begin
            out_kind_reg <= ld_kind;
            out_acc_reg  <= ld_acc;
            out_ev_reg   <= ld_ev;
            out_ent_reg  <= ld_ent;
            out_fill_reg <= ld_fill;
            out_last_reg <= ld_last;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.result_kind = out_kind_reg;
    assign rsp.accepted    = out_acc_reg;
    assign rsp.evicted     = out_ev_reg;
    assign rsp.out_entity  = out_ent_reg.entity;
    assign rsp.out_score   = out_ent_reg.score;
    assign rsp.out_owned   = out_ent_reg.owned;
    assign rsp.fill_count  = out_fill_reg;
    assign rsp.last        = out_last_reg;

endmodule

// ===== rtl/tkh_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Top-k heap selector checker
// Port-level properties of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module tkh_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            rsp_valid,
    input logic                            rsp_ready,
    input logic [1:0]                      result_kind,
    input logic                            accepted,
    input logic                            evicted,
    input logic [tkh_pkg::ENTITY_BITS-1:0] out_entity,
    input logic [tkh_pkg::FILL_W-1:0]      fill_count,
    input logic                            last
);
    import tkh_pkg::*;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(out_entity) && $stable(result_kind))
        else $error("result changed while stalled");

    a_flush_entry: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (result_kind == KIND_ENTRY) |-> (fill_count == '0) && !accepted && !evicted)
        else $error("flushed entry with nonzero fill or insert flags");

    a_single: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && ((result_kind == KIND_INSERT) || (result_kind == KIND_EMPTY)) |-> last)
        else $error("single-result item without last");

    a_evict: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (result_kind == KIND_INSERT) && !evicted |-> (out_entity == '0))
        else $error("insert outcome without eviction carries an entry");

    a_evict_acc: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && evicted |-> accepted && (fill_count != '0))
        else $error("eviction without acceptance");

endmodule

bind bounded_top_k_heap_selector_top tkh_checker u_tkh_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .result_kind (rsp.result_kind),
    .accepted    (rsp.accepted),
    .evicted     (rsp.evicted),
    .out_entity  (rsp.out_entity),
    .fill_count  (rsp.fill_count),
    .last        (rsp.last)
);
